[rtl/qsort_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_pkg
// shared types and constants for the quicksort engine
// ----------------------------------------------------------------------------
package qsort_pkg;

   localparam int ValueWidth = 64;
   localparam int IdxWidth   = 7;

   typedef struct packed {
      logic [ValueWidth-1:0] value_in;
      logic                  last_in;
   } req_beat_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value_out;
      logic                  last_out;
      logic                  overflow;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_POP,
      ST_POP_WAIT,
      ST_PIVOT_RD,
      ST_PIVOT_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_BACK_RD,
      ST_BACK_WAIT,
      ST_PUSH_LO,
      ST_PUSH_HI,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_HOLD
   } state_type;

   // signed a <= b
   function automatic logic le_signed(input logic [ValueWidth-1:0] a,
                                      input logic [ValueWidth-1:0] b);
      le_signed = $signed(a) <= $signed(b);
   endfunction

endpackage

[rtl/quicksort_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine
// loads a set of signed 64-bit values and returns it sorted ascending
// ----------------------------------------------------------------------------
// channel | direction | beat payload
// req_    | in        | value_in, last_in
// rsp_    | out       | value_out, last_out, overflow
//
// load accepts one beat per cycle; after the last beat the block leaves req_
// stalled while it sorts and emits. each split reads the range once into a
// scratch ram and writes it back into the item store, so sorting is slowest
// when the middle pivot keeps landing at one end, and its speed is bounded
// by the single ports of the item store and scratch ram. each emitted beat
// steps through a read, a wait and a hold state, and the hold lasts while
// rsp_ stalls.
// reset is synchronous and clears the control state.
module quicksort_engine #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  qsort_pkg::req_beat_type   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output qsort_pkg::rsp_beat_type   rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = AW + 1;
   localparam int VW = qsort_pkg::ValueWidth;

   qsort_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] s_ff, s_in, e_ff, e_in, i_ff, i_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [VW-1:0] pivot_ff, pivot_in;
   logic          last_ff, last_in;

   // ram ports
   logic            st_we, sb_we, rs_we;
   logic [AW-1:0]   st_addr, sb_addr, rs_addr;
   logic [VW-1:0]   st_wd, sb_wd, st_rd, sb_rd;
   logic [2*CW-1:0] rs_wd, rs_rd;

   qsort_ram #(.Width(VW), .Depth(MAX_ITEMS)) u_store (
      .clock(clock), .wr_en(st_we), .addr(st_addr), .wr_data(st_wd), .rd_data(st_rd));
   qsort_ram #(.Width(VW), .Depth(MAX_ITEMS)) u_split (
      .clock(clock), .wr_en(sb_we), .addr(sb_addr), .wr_data(sb_wd), .rd_data(sb_rd));
   qsort_ram #(.Width(2*CW), .Depth(MAX_ITEMS)) u_stack (
      .clock(clock), .wr_en(rs_we), .addr(rs_addr), .wr_data(rs_wd), .rd_data(rs_rd));

   logic [CW-1:0] mid, len, pv_slot;
   assign mid     = CW'((s_ff + e_ff) >> 1);
   assign len     = e_ff - s_ff;
   assign pv_slot = s_ff + lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qsort_pkg::ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         sp_ff    <= sp_in;
      end
      s_ff     <= s_in;
      e_ff     <= e_in;
      i_ff     <= i_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pivot_ff <= pivot_in;
      last_ff  <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      sp_in    = sp_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      i_in     = i_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      pivot_in = pivot_ff;
      last_in  = last_ff;
      st_we    = 1'b0;
      sb_we    = 1'b0;
      rs_we    = 1'b0;
      st_addr  = i_ff[AW-1:0];
      sb_addr  = '0;
      rs_addr  = sp_ff[AW-1:0];
      st_wd    = sb_rd;
      sb_wd    = st_rd;
      rs_wd    = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_data  = '{value_out: st_rd, last_out: last_ff, overflow: drop_ff};
      case (state_ff)
         qsort_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            st_addr   = count_ff[AW-1:0];
            st_wd     = req_data.value_in;
            if (req_valid) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last_in) begin
                  // push the whole set if it has two or more values
                  s_in = '0;
                  e_in = count_in;
                  lo_in = count_in;
                  hi_in = '0;
                  sp_in = '0;
                  i_in  = '0;
                  state_in = qsort_pkg::ST_PUSH_LO;
               end
            end
         end
         qsort_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               i_in = '0;
               state_in = (count_ff == '0) ? qsort_pkg::ST_LOAD : qsort_pkg::ST_EMIT_RD;
               if (count_ff == '0) drop_in = 1'b0;
            end else begin
               sp_in   = sp_ff - 1'b1;
               rs_addr = sp_in[AW-1:0];
               state_in = qsort_pkg::ST_POP_WAIT;
            end
         end
         qsort_pkg::ST_POP_WAIT: begin
            s_in = rs_rd[2*CW-1:CW];
            e_in = rs_rd[CW-1:0];
            state_in = qsort_pkg::ST_PIVOT_RD;
         end
         qsort_pkg::ST_PIVOT_RD: begin
            st_addr = mid[AW-1:0];
            lo_in = '0;
            hi_in = '0;
            i_in  = s_ff;
            state_in = qsort_pkg::ST_PIVOT_WAIT;
         end
         qsort_pkg::ST_PIVOT_WAIT: begin
            pivot_in = st_rd;
            state_in = qsort_pkg::ST_SCAN_RD;
         end
         qsort_pkg::ST_SCAN_RD: begin
            if (i_ff == e_ff) begin
               i_in = '0;
               state_in = qsort_pkg::ST_BACK_RD;
            end else if (i_ff == mid) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = qsort_pkg::ST_SCAN_WAIT;
            end
         end
         qsort_pkg::ST_SCAN_WAIT: begin
            // shared compare: low side fills up, high side fills down
            sb_we = 1'b1;
            if (qsort_pkg::le_signed(st_rd, pivot_ff)) begin
               sb_addr = lo_ff[AW-1:0];
               lo_in   = lo_ff + 1'b1;
            end else begin
               sb_addr = AW'(len - 1'b1 - hi_ff);
               hi_in   = hi_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
            state_in = qsort_pkg::ST_SCAN_RD;
         end
         qsort_pkg::ST_BACK_RD: begin
            // i walks scratch slots 0..len-1; slot lo is skipped and the pivot goes to that place in the store
            if (i_ff == len) begin
               state_in = qsort_pkg::ST_PUSH_LO;
            end else if (i_ff == lo_ff) begin
               st_we   = 1'b1;
               st_addr = pv_slot[AW-1:0];
               st_wd   = pivot_ff;
               i_in    = i_ff + 1'b1;
            end else begin
               sb_addr = i_ff[AW-1:0];
               state_in = qsort_pkg::ST_BACK_WAIT;
            end
         end
         qsort_pkg::ST_BACK_WAIT: begin
            st_we   = 1'b1;
            st_addr = AW'(s_ff + i_ff);
            i_in    = i_ff + 1'b1;
            state_in = qsort_pkg::ST_BACK_RD;
         end
         qsort_pkg::ST_PUSH_LO: begin
            if (lo_ff >= CW'(2)) begin
               rs_we = 1'b1;
               rs_wd = {s_ff, pv_slot};
               sp_in = sp_ff + 1'b1;
            end
            state_in = qsort_pkg::ST_PUSH_HI;
         end
         qsort_pkg::ST_PUSH_HI: begin
            if (hi_ff >= CW'(2)) begin
               rs_we = 1'b1;
               rs_wd = {CW'(pv_slot + 1'b1), e_ff};
               sp_in = sp_ff + 1'b1;
            end
            state_in = qsort_pkg::ST_POP;
         end
         qsort_pkg::ST_EMIT_RD: begin
            st_addr = i_ff[AW-1:0];
            last_in = (CW'(i_ff + 1'b1) == count_ff);
            state_in = qsort_pkg::ST_EMIT_WAIT;
         end
         qsort_pkg::ST_EMIT_WAIT: begin
            state_in = qsort_pkg::ST_EMIT_HOLD;
         end
         qsort_pkg::ST_EMIT_HOLD: begin
            // rd data holds while the ram address stays put
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               i_in = i_ff + 1'b1;
               if (last_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = qsort_pkg::ST_LOAD;
               end else begin
                  state_in = qsort_pkg::ST_EMIT_RD;
               end
            end
         end
         default: state_in = qsort_pkg::ST_LOAD;
      endcase
   end

   // stack never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset) sp_ff <= CW'(MAX_ITEMS))
      else $error("range stack overrun");
   // a range taken off the stack lies within the set
   assert property (@(posedge clock) disable iff (reset)
      state_ff == qsort_pkg::ST_PIVOT_RD |-> (e_ff <= count_ff && s_ff < e_ff))
      else $error("range out of bounds");
   // the split accounts for every non-pivot element
   assert property (@(posedge clock) disable iff (reset)
      state_ff == qsort_pkg::ST_BACK_RD && i_ff == '0 |-> CW'(lo_ff + hi_ff + 1'b1) == len)
      else $error("split count mismatch");

endmodule

[rtl/qsort_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module qsort_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule
